// ===== hw/rtl/spd_pkg.sv =====
// spd_pkg: shared types and constants of the spectrum peak detector
// no dependencies; used by the channel interfaces and all rtl modules
package spd_pkg;

  localparam int unsigned IQ_W      = 24;
  localparam int unsigned FREQ_W    = 32;
  localparam int unsigned MAG_W     = 24;
  localparam int unsigned SQ_W      = 48;
  localparam int unsigned SUM_W     = 36;
  localparam int unsigned IDX_OUT_W = 12;
  localparam int unsigned CNT_OUT_W = 13;
  localparam int unsigned SCALE_W   = 8;
  localparam int unsigned PROD_W    = SUM_W + SCALE_W;
  localparam int unsigned STEP_W    = 6;

  localparam logic [STEP_W-1:0] ROOT_STEPS_M1 = STEP_W'(MAG_W - 1);
  localparam logic [STEP_W-1:0] DIV_STEPS_M1  = STEP_W'(SUM_W - 1);

  localparam logic [SUM_W-1:0]   SUM_MAX       = '1;
  localparam logic [SCALE_W-1:0] THRESH_RESET  = 8'd10;

  // register map
  localparam int unsigned  APB_ADDR_W         = 3;
  localparam int unsigned  APB_DATA_W         = 32;
  localparam logic [APB_ADDR_W-1:0] ADDR_THRESHOLD_SCALE = 3'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ_A,
    ST_SQ_B,
    ST_ROOT,
    ST_STATS,
    ST_DIV,
    ST_SCALE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic sq_b;
    logic sq_sum;
    logic root_step;
    logic stats;
    logic div_step;
    logic scale;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic step_last;
    logic frame_last;
  } status_t;

endpackage

// ===== hw/rtl/spd_in_if.sv =====
// spd_in_if: input bin channel, valid/ready with bin payload
// depends on spd_pkg for field widths
interface spd_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [spd_pkg::IQ_W-1:0]   i_value;
  logic signed [spd_pkg::IQ_W-1:0]   q_value;
  logic signed [spd_pkg::FREQ_W-1:0] bin_frequency;
  logic                              frame_last;

  modport source (output valid, i_value, q_value, bin_frequency, frame_last, input ready);
  modport sink   (input valid, i_value, q_value, bin_frequency, frame_last, output ready);
endinterface

// ===== hw/rtl/spd_out_if.sv =====
// spd_out_if: result channel, valid/ready with magnitude and frame summary
// depends on spd_pkg for field widths
interface spd_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [spd_pkg::MAG_W-1:0]            magnitude;
  logic                                 frame_done;
  logic [spd_pkg::MAG_W-1:0]            peak_amplitude;
  logic signed [spd_pkg::FREQ_W-1:0]    peak_frequency;
  logic [spd_pkg::IDX_OUT_W-1:0]        peak_index;
  logic [spd_pkg::MAG_W-1:0]            mean_amplitude;
  logic [spd_pkg::SUM_W-1:0]            amplitude_sum;
  logic                                 peak_found;
  logic [spd_pkg::CNT_OUT_W-1:0]        bin_count;

  modport source (output valid, magnitude, frame_done, peak_amplitude, peak_frequency,
                  peak_index, mean_amplitude, amplitude_sum, peak_found, bin_count,
                  input ready);
  modport sink   (input valid, magnitude, frame_done, peak_amplitude, peak_frequency,
                  peak_index, mean_amplitude, amplitude_sum, peak_found, bin_count,
                  output ready);
endinterface

// ===== hw/rtl/spectrum_peak_detector_unit.sv =====
// spectrum_peak_detector_unit: top level of the fft magnitude peak detector
// depends on spd_pkg, spd_in_if, spd_out_if, spd_ctrl and spd_datapath
//
// One bin is worked at a time. A bin that is not the last of its frame goes
// from transfer to result through the squaring states, the bit-serial square
// root, one statistics update and one output load; the last bin of a frame
// also passes the 36-step serial divider that forms the mean, and the threshold
// multiply. The result sits in an output register, so a new bin is taken while
// the previous result waits. Bins past MAX_BINS in a frame still get a
// magnitude but do not enter peak, sum or count. threshold_scale is written
// over the apb-style port at byte address 0.
module spectrum_peak_detector_unit #(
  parameter int unsigned MAX_BINS = 4096
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  spd_in_if.sink                                in_if,
  spd_out_if.source                             out_if,
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [spd_pkg::APB_ADDR_W-1:0]        cfg_paddr,
  input  logic [spd_pkg::APB_DATA_W-1:0]        cfg_pwdata,
  output logic [spd_pkg::APB_DATA_W-1:0]        cfg_prdata,
  output logic                                  cfg_pready
);

  spd_pkg::cmd_t               cmd;
  spd_pkg::status_t            sts;
  logic [spd_pkg::SCALE_W-1:0] scale_r;

  // config register, written in the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= spd_pkg::THRESH_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite
                 && (cfg_paddr == spd_pkg::ADDR_THRESHOLD_SCALE)) begin
      scale_r <= cfg_pwdata[spd_pkg::SCALE_W-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  // reads of unmapped addresses return zero
  assign cfg_prdata = (cfg_paddr == spd_pkg::ADDR_THRESHOLD_SCALE)
                    ? spd_pkg::APB_DATA_W'(scale_r) : '0;

  spd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  spd_datapath #(
    .MAX_BINS (MAX_BINS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .scale          (scale_r),
    .i_value        (in_if.i_value),
    .q_value        (in_if.q_value),
    .bin_frequency  (in_if.bin_frequency),
    .frame_last     (in_if.frame_last),
    .magnitude      (out_if.magnitude),
    .frame_done     (out_if.frame_done),
    .peak_amplitude (out_if.peak_amplitude),
    .peak_frequency (out_if.peak_frequency),
    .peak_index     (out_if.peak_index),
    .mean_amplitude (out_if.mean_amplitude),
    .amplitude_sum  (out_if.amplitude_sum),
    .peak_found     (out_if.peak_found),
    .bin_count      (out_if.bin_count)
  );

endmodule

// ===== hw/rtl/spd_ctrl.sv =====
// spd_ctrl: sequencing state machine and output valid flag
// depends on spd_pkg (state_t, cmd_t, status_t)
module spd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  spd_pkg::status_t sts,
  output spd_pkg::cmd_t    cmd
);

  spd_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      spd_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = spd_pkg::ST_SQ_A;
        end
      end
      spd_pkg::ST_SQ_A: begin
        cmd.sq_b  = 1'b1;
        state_nxt = spd_pkg::ST_SQ_B;
      end
      spd_pkg::ST_SQ_B: begin
        cmd.sq_sum = 1'b1;
        state_nxt  = spd_pkg::ST_ROOT;
      end
      spd_pkg::ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (sts.step_last) state_nxt = spd_pkg::ST_STATS;
      end
      spd_pkg::ST_STATS: begin
        cmd.stats = 1'b1;
        state_nxt = sts.frame_last ? spd_pkg::ST_DIV : spd_pkg::ST_EMIT;
      end
      spd_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.step_last) state_nxt = spd_pkg::ST_SCALE;
      end
      spd_pkg::ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = spd_pkg::ST_EMIT;
      end
      spd_pkg::ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = spd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = spd_pkg::ST_IDLE;
    endcase
  end

  assign in_ready  = (state_r == spd_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== hw/rtl/spd_datapath.sv =====
// spd_datapath: squares, bit-serial root, frame statistics, serial divider
// depends on spd_pkg; driven by spd_ctrl commands
module spd_datapath #(
  parameter int unsigned MAX_BINS = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  spd_pkg::cmd_t                        cmd,
  output spd_pkg::status_t                     sts,
  input  logic [spd_pkg::SCALE_W-1:0]          scale,
  input  logic signed [spd_pkg::IQ_W-1:0]      i_value,
  input  logic signed [spd_pkg::IQ_W-1:0]      q_value,
  input  logic signed [spd_pkg::FREQ_W-1:0]    bin_frequency,
  input  logic                                 frame_last,
  output logic [spd_pkg::MAG_W-1:0]            magnitude,
  output logic                                 frame_done,
  output logic [spd_pkg::MAG_W-1:0]            peak_amplitude,
  output logic signed [spd_pkg::FREQ_W-1:0]    peak_frequency,
  output logic [spd_pkg::IDX_OUT_W-1:0]        peak_index,
  output logic [spd_pkg::MAG_W-1:0]            mean_amplitude,
  output logic [spd_pkg::SUM_W-1:0]            amplitude_sum,
  output logic                                 peak_found,
  output logic [spd_pkg::CNT_OUT_W-1:0]        bin_count
);

  localparam int unsigned CW = $clog2(MAX_BINS + 1);
  localparam int unsigned IW = $clog2(MAX_BINS);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BINS);

  localparam int unsigned MW = spd_pkg::MAG_W;
  localparam int unsigned SW = spd_pkg::SUM_W;

  // bin registers
  logic [MW-1:0]                      ai_r, aq_r;
  logic [spd_pkg::FREQ_W-1:0]         freq_r;
  logic                               last_r;
  logic [spd_pkg::SQ_W-1:0]           sq_r, rad_r;
  logic [MW+1:0]                      rem_r;
  logic [MW-1:0]                      root_r;
  logic [spd_pkg::STEP_W-1:0]         step_r;

  // frame statistics
  logic [MW-1:0]                      fpk_amp_r;
  logic [spd_pkg::FREQ_W-1:0]         fpk_freq_r;
  logic [IW-1:0]                      fpk_idx_r;
  logic [SW-1:0]                      sum_r;
  logic [CW-1:0]                      seen_r;
  logic [MW-1:0]                      rep_amp_r;
  logic [spd_pkg::FREQ_W-1:0]         rep_freq_r;

  // divider and threshold
  logic [SW-1:0]                      dq_r;
  logic [CW-1:0]                      drem_r;
  logic [spd_pkg::PROD_W-1:0]         prod_r;

  // output register
  logic [MW-1:0]                      o_mag_r, o_pamp_r, o_mean_r;
  logic [spd_pkg::FREQ_W-1:0]         o_pfreq_r;
  logic [spd_pkg::IDX_OUT_W-1:0]      o_pidx_r;
  logic [SW-1:0]                      o_sum_r;
  logic [spd_pkg::CNT_OUT_W-1:0]      o_cnt_r;
  logic                               o_done_r, o_found_r;

  logic [MW+3:0]                      rt_shift, rt_trial, rt_diff;
  logic                               rt_ge;
  logic [CW:0]                        dv_shift, dv_diff;
  logic                               dv_ge;
  logic [SW:0]                        sum_ext;
  logic [SW-1:0]                      mean;
  logic                               found;

  function automatic logic [MW-1:0] abs_iq(input logic signed [MW-1:0] v);
    abs_iq = v[MW-1] ? MW'(-v) : MW'(v);
  endfunction

  // one root bit per step
  assign rt_shift = {rem_r, rad_r[spd_pkg::SQ_W-1 -: 2]};
  assign rt_trial = {2'b00, root_r, 2'b01};
  assign rt_diff  = rt_shift - rt_trial;
  assign rt_ge    = (rt_shift >= rt_trial);

  // one quotient bit per step
  assign dv_shift = {drem_r, dq_r[SW-1]};
  assign dv_diff  = dv_shift - {1'b0, seen_r};
  assign dv_ge    = (dv_shift >= {1'b0, seen_r});

  assign sum_ext = {1'b0, sum_r} + (SW+1)'(root_r);
  assign mean    = (seen_r != '0) ? dq_r : '0;
  assign found   = ({{(spd_pkg::PROD_W-MW){1'b0}}, fpk_amp_r} > prod_r);

  assign sts.step_last  = (step_r == '0);
  assign sts.frame_last = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fpk_amp_r  <= '0;
      fpk_freq_r <= '0;
      fpk_idx_r  <= '0;
      sum_r      <= '0;
      seen_r     <= '0;
      rep_amp_r  <= '0;
      rep_freq_r <= '0;
    end else begin
      if (cmd.stats && (seen_r < MAX_CNT)) begin
        if (root_r > fpk_amp_r) begin
          fpk_amp_r  <= root_r;
          fpk_freq_r <= freq_r;
          fpk_idx_r  <= seen_r[IW-1:0];
        end
        sum_r  <= sum_ext[SW] ? spd_pkg::SUM_MAX : sum_ext[SW-1:0];
        seen_r <= seen_r + CW'(1);
      end
      if (cmd.emit && last_r) begin
        if (found) begin
          rep_amp_r  <= fpk_amp_r;
          rep_freq_r <= fpk_freq_r;
        end
        fpk_amp_r  <= '0;
        fpk_freq_r <= '0;
        fpk_idx_r  <= '0;
        sum_r      <= '0;
        seen_r     <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ai_r   <= abs_iq(i_value);
      aq_r   <= abs_iq(q_value);
      freq_r <= bin_frequency;
      last_r <= frame_last;
      sq_r   <= '0;
    end
    if (cmd.sq_b) begin
      sq_r <= ai_r * ai_r;
    end
    if (cmd.sq_b) begin
      rem_r  <= '0;
      root_r <= '0;
      step_r <= spd_pkg::ROOT_STEPS_M1;
    end
    // second square is added in the cycle after the first is registered
    if (cmd.sq_sum) begin
      rad_r <= sq_r + aq_r * aq_r;
    end
    if (cmd.root_step) begin
      rad_r  <= rad_r << 2;
      rem_r  <= rt_ge ? rt_diff[MW+1:0] : rt_shift[MW+1:0];
      root_r <= {root_r[MW-2:0], rt_ge};
      step_r <= step_r - spd_pkg::STEP_W'(1);
    end
    if (cmd.stats) begin
      // dividend is the sum as it stands after this bin
      if (seen_r < MAX_CNT) begin
        dq_r <= sum_ext[SW] ? spd_pkg::SUM_MAX : sum_ext[SW-1:0];
      end else begin
        dq_r <= sum_r;
      end
      drem_r <= '0;
      step_r <= spd_pkg::DIV_STEPS_M1;
    end
    if (cmd.div_step) begin
      dq_r   <= {dq_r[SW-2:0], dv_ge};
      drem_r <= dv_ge ? dv_diff[CW-1:0] : dv_shift[CW-1:0];
      step_r <= step_r - spd_pkg::STEP_W'(1);
    end
    if (cmd.scale) begin
      prod_r <= scale * mean;
    end
    if (cmd.emit) begin
      o_mag_r <= root_r;
      o_done_r <= last_r;
      if (last_r) begin
        o_pamp_r  <= found ? fpk_amp_r : rep_amp_r;
        o_pfreq_r <= found ? fpk_freq_r : rep_freq_r;
        o_pidx_r  <= spd_pkg::IDX_OUT_W'(fpk_idx_r);
        o_mean_r  <= MW'(mean);
        o_sum_r   <= sum_r;
        o_found_r <= found;
        o_cnt_r   <= spd_pkg::CNT_OUT_W'(seen_r);
      end else begin
        o_pamp_r  <= '0;
        o_pfreq_r <= '0;
        o_pidx_r  <= '0;
        o_mean_r  <= '0;
        o_sum_r   <= '0;
        o_found_r <= 1'b0;
        o_cnt_r   <= '0;
      end
    end
  end

  assign magnitude      = o_mag_r;
  assign frame_done     = o_done_r;
  assign peak_amplitude = o_pamp_r;
  assign peak_frequency = o_pfreq_r;
  assign peak_index     = o_pidx_r;
  assign mean_amplitude = o_mean_r;
  assign amplitude_sum  = o_sum_r;
  assign peak_found     = o_found_r;
  assign bin_count      = o_cnt_r;

endmodule

// ===== hw/rtl/spd_checker.sv =====
// spd_checker: port-level assertions for spectrum_peak_detector_unit
// depends on spd_pkg widths; bound to the top level below
module spd_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic                                frame_done,
  input logic [spd_pkg::MAG_W-1:0]           peak_amplitude,
  input logic [spd_pkg::SUM_W-1:0]           amplitude_sum,
  input logic                                peak_found,
  input logic [spd_pkg::CNT_OUT_W-1:0]       bin_count
);

  // result stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // one bin in flight: input closes after a transfer
  a_one_bin: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input open while a bin is in flight");

  // summary fields are clear on bins inside a frame
  a_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !frame_done |-> peak_amplitude == '0 && amplitude_sum == '0
                                 && !peak_found && bin_count == '0)
    else $error("summary fields set on a mid-frame bin");

  // a frame is never reported with zero bins
  a_frame_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_done |-> bin_count != '0)
    else $error("frame reported with zero bins");

endmodule

bind spectrum_peak_detector_unit spd_checker u_spd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_if.valid),
  .in_ready       (in_if.ready),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .frame_done     (out_if.frame_done),
  .peak_amplitude (out_if.peak_amplitude),
  .amplitude_sum  (out_if.amplitude_sum),
  .peak_found     (out_if.peak_found),
  .bin_count      (out_if.bin_count)
);
